>>> rtl/nps_pkg.sv
// ----------------------------------------------------------------------------
// nps_pkg: shared types, constants and microcode for the next-prime search
// Datapath widths, control word layout and the sequencer program.
// ----------------------------------------------------------------------------
package nps_pkg;

  localparam int WIDTH       = 32;
  localparam int IN_TDATA_W  = ((WIDTH + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((WIDTH + 2 + 7) / 8) * 8;
  localparam int SQ_W        = WIDTH + 2;
  localparam int CNT_W       = $clog2(WIDTH + 1);
  localparam int UC_DEPTH    = 18;
  localparam int PC_W        = $clog2(UC_DEPTH);

  typedef logic [PC_W-1:0] pc_t;

  typedef enum logic [3:0] {
    O_NOP    = 4'd0,
    O_CLRP   = 4'd1,
    O_SETP   = 4'd2,
    O_DINIT  = 4'd3,
    O_MSTART = 4'd4,
    O_MSTEP  = 4'd5,
    O_DSTEP  = 4'd6,
    O_SAVEN  = 4'd7,
    O_INC    = 4'd8,
    O_EMIT_F = 4'd9,
    O_EMIT_N = 4'd10
  } op_t;

  typedef enum logic [3:0] {
    C_NEVER    = 4'd0,
    C_ALWAYS   = 4'd1,
    C_NO_IN    = 4'd2,
    C_LT2      = 4'd3,
    C_LT4      = 4'd4,
    C_EVEN     = 4'd5,
    C_SQ_GT    = 4'd6,
    C_MOD_MORE = 4'd7,
    C_REM_NZ   = 4'd8,
    C_PH_N     = 4'd9,
    C_TPRIME   = 4'd10,
    C_CAND_MAX = 4'd11,
    C_OUT_FULL = 4'd12
  } cond_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   tgt;
  } ucw_t;

  // program addresses
  localparam pc_t S_IDLE  = pc_t'(0);
  localparam pc_t S_TEST  = pc_t'(1);
  localparam pc_t S_LOOP  = pc_t'(5);
  localparam pc_t S_MOD   = pc_t'(6);
  localparam pc_t S_RET   = pc_t'(9);
  localparam pc_t S_NEXT  = pc_t'(11);
  localparam pc_t S_SAVEN = pc_t'(13);
  localparam pc_t S_FOUND = pc_t'(14);
  localparam pc_t S_NONE  = pc_t'(16);

  function automatic ucw_t ucode_rd(input pc_t pc);
    ucw_t w;
    begin
      case (pc)
        pc_t'(0):  w = '{O_NOP,    C_NO_IN,    S_IDLE};
        pc_t'(1):  w = '{O_CLRP,   C_LT2,      S_RET};
        pc_t'(2):  w = '{O_SETP,   C_LT4,      S_RET};
        pc_t'(3):  w = '{O_CLRP,   C_EVEN,     S_RET};
        pc_t'(4):  w = '{O_DINIT,  C_NEVER,    S_IDLE};
        pc_t'(5):  w = '{O_MSTART, C_SQ_GT,    S_RET};
        pc_t'(6):  w = '{O_MSTEP,  C_MOD_MORE, S_MOD};
        pc_t'(7):  w = '{O_DSTEP,  C_REM_NZ,   S_LOOP};
        pc_t'(8):  w = '{O_CLRP,   C_ALWAYS,   S_RET};
        pc_t'(9):  w = '{O_NOP,    C_PH_N,     S_SAVEN};
        pc_t'(10): w = '{O_NOP,    C_TPRIME,   S_FOUND};
        pc_t'(11): w = '{O_NOP,    C_CAND_MAX, S_NONE};
        pc_t'(12): w = '{O_INC,    C_ALWAYS,   S_TEST};
        pc_t'(13): w = '{O_SAVEN,  C_ALWAYS,   S_NEXT};
        pc_t'(14): w = '{O_EMIT_F, C_OUT_FULL, S_FOUND};
        pc_t'(15): w = '{O_NOP,    C_ALWAYS,   S_IDLE};
        pc_t'(16): w = '{O_EMIT_N, C_OUT_FULL, S_NONE};
        pc_t'(17): w = '{O_NOP,    C_ALWAYS,   S_IDLE};
        default:   w = '{O_NOP,    C_ALWAYS,   S_IDLE};
      endcase
      return w;
    end
  endfunction

endpackage

>>> rtl/next_prime_search_core.sv
// ----------------------------------------------------------------------------
// next_prime_search_core: primality test and next-prime search
// Trial division driven by a microcoded sequencer over a shared
// restoring modulo unit.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one beat carries the number (tdata[WIDTH-1:0]).
//   out_* : one beat per input beat; tdata from bit 0 up holds
//           the prime flag of the number, next_prime (WIDTH bits),
//           no_prime_fits.
//   One item is worked on at a time; in_tready is high only while the
//   sequencer sits at its idle step.
//   Cost per candidate c: the small/even checks, then one modulo pass per
//   odd divisor d from 3 upward with d*d <= c. The
//   bit-serial modulo unit (one quotient bit per cycle) sets the cost of each pass.
//   The number itself is tested first, then n+1, n+2, ... until a prime
//   appears. A prime candidate near 2^32 runs about 32768 divisors.
//   The result sits in an output register; the next item is accepted while
//   it waits. If the receiver stalls, the sequencer holds at its emit step
//   until the register frees up.
//   Reset (rst_n low, synchronous) returns the sequencer to idle and
//   drops out_tvalid. No clearing pass is needed.
// ----------------------------------------------------------------------------
module next_prime_search_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [nps_pkg::IN_TDATA_W-1:0] in_tdata,  // number
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [nps_pkg::OUT_TDATA_W-1:0] out_tdata // prime flag, next_prime, no_prime_fits
);
  import nps_pkg::*;

  pc_t               pc_r, pc_nxt;
  logic [WIDTH-1:0]  cand_r, cand_nxt;
  logic [WIDTH-1:0]  d_r, d_nxt;
  logic [SQ_W-1:0]   sq_r, sq_nxt;
  logic [WIDTH-1:0]  rem_r, rem_nxt;
  logic [WIDTH-1:0]  sh_r, sh_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              t_r, t_nxt;
  logic              ph_r, ph_nxt;
  logic              np_r, np_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic              out_prime_r, out_prime_nxt;
  logic [WIDTH-1:0]  out_next_r, out_next_nxt;
  logic              out_none_r, out_none_nxt;

  ucw_t              uc;
  logic              in_fire;
  logic              slot_free;
  logic              cond_hit;
  logic [WIDTH:0]    r_sh;
  logic              r_ge;

  assign uc        = ucode_rd(pc_r);
  assign in_tready = (pc_r == S_IDLE);
  assign in_fire   = in_tvalid && in_tready;
  assign slot_free = !out_valid_r || out_tready;

  assign r_sh = {rem_r, sh_r[WIDTH-1]};
  assign r_ge = (r_sh >= {1'b0, d_r});

  always_comb begin
    case (uc.cond)
      C_NEVER:    cond_hit = 1'b0;
      C_ALWAYS:   cond_hit = 1'b1;
      C_NO_IN:    cond_hit = !in_fire;
      C_LT2:      cond_hit = (cand_r[WIDTH-1:1] == '0);
      C_LT4:      cond_hit = (cand_r[WIDTH-1:2] == '0);
      C_EVEN:     cond_hit = !cand_r[0];
      C_SQ_GT:    cond_hit = (sq_r > {2'b00, cand_r});
      C_MOD_MORE: cond_hit = (cnt_r > CNT_W'(1));
      C_REM_NZ:   cond_hit = (rem_r != '0);
      C_PH_N:     cond_hit = !ph_r;
      C_TPRIME:   cond_hit = t_r;
      C_CAND_MAX: cond_hit = (cand_r == '1);
      C_OUT_FULL: cond_hit = !slot_free;
      default:    cond_hit = 1'b0;
    endcase
  end

  always_comb begin
    pc_nxt        = cond_hit ? uc.tgt : pc_t'(pc_r + pc_t'(1));
    cand_nxt      = cand_r;
    d_nxt         = d_r;
    sq_nxt        = sq_r;
    rem_nxt       = rem_r;
    sh_nxt        = sh_r;
    cnt_nxt       = cnt_r;
    t_nxt         = t_r;
    ph_nxt        = ph_r;
    np_nxt        = np_r;
    out_prime_nxt = out_prime_r;
    out_next_nxt  = out_next_r;
    out_none_nxt  = out_none_r;
    out_valid_nxt = out_tready ? 1'b0 : out_valid_r;

    if (in_fire) begin
      cand_nxt = in_tdata[WIDTH-1:0];
      ph_nxt   = 1'b0;
    end

    case (uc.op)
      O_NOP: begin
      end
      O_CLRP: t_nxt = 1'b0;
      O_SETP: t_nxt = 1'b1;
      O_DINIT: begin
        d_nxt  = WIDTH'(3);
        sq_nxt = SQ_W'(9);
        t_nxt  = 1'b1;
      end
      O_MSTART: begin
        rem_nxt = '0;
        sh_nxt  = cand_r;
        cnt_nxt = CNT_W'(WIDTH);
      end
      O_MSTEP: begin
        rem_nxt = r_ge ? WIDTH'(r_sh - {1'b0, d_r}) : r_sh[WIDTH-1:0];
        sh_nxt  = {sh_r[WIDTH-2:0], 1'b0};
        cnt_nxt = cnt_r - CNT_W'(1);
      end
      O_DSTEP: begin
        d_nxt  = d_r + WIDTH'(2);
        sq_nxt = sq_r + {d_r, 2'b00} + SQ_W'(4);
      end
      O_SAVEN: begin
        np_nxt = t_r;
        ph_nxt = 1'b1;
      end
      O_INC: cand_nxt = cand_r + WIDTH'(1);
      O_EMIT_F: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = np_r;
          out_next_nxt  = cand_r;
          out_none_nxt  = 1'b0;
        end
      end
      O_EMIT_N: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_prime_nxt = np_r;
          out_next_nxt  = '0;
          out_none_nxt  = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r        <= S_IDLE;
      out_valid_r <= 1'b0;
      ph_r        <= 1'b0;
      cnt_r       <= '0;
    end else begin
      pc_r        <= pc_nxt;
      out_valid_r <= out_valid_nxt;
      ph_r        <= ph_nxt;
      cnt_r       <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cand_r      <= cand_nxt;
    d_r         <= d_nxt;
    sq_r        <= sq_nxt;
    rem_r       <= rem_nxt;
    sh_r        <= sh_nxt;
    t_r         <= t_nxt;
    np_r        <= np_nxt;
    out_prime_r <= out_prime_nxt;
    out_next_r  <= out_next_nxt;
    out_none_r  <= out_none_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_TDATA_W'({out_none_r, out_next_r, out_prime_r});

  a_pc_range: assert property (@(posedge clk) disable iff (!rst_n)
    pc_r < pc_t'(UC_DEPTH))
    else $error("sequencer left program");

  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(WIDTH))
    else $error("modulo step count out of range");

  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_none_r |-> out_next_r == '0)
    else $error("no-fit result carries a value");

  a_found_ge2: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_none_r |-> out_next_r > WIDTH'(1))
    else $error("found value below two");

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |=> out_valid_r && $stable(out_next_r))
    else $error("pending result overwritten");

endmodule

>>> bench/next_prime_search_core_test.sv
// ----------------------------------------------------------------------------
// next_prime_search_core_test: self-checking bench for next_prime_search_core
// Streams numbers into the core, predicts primality and the next prime by
// trial division, and checks every result beat field by field against the
// oldest prediction. Random stalls on both sides; mostly small numbers so
// the bit-serial divider keeps the run short, plus the cheap top-of-range
// cases where no larger prime fits.
// ----------------------------------------------------------------------------
module next_prime_search_core_test;
  import nps_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int RANDOM_ITEMS = 80;
  localparam int QUIET_TAIL   = 20;

  typedef struct {
    logic [WIDTH-1:0] number;
    bit               num_prime;
    logic [WIDTH-1:0] next_prime;
    bit               none_fits;
  } prime_answer_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [WIDTH-1:0] pending_numbers[$];
  prime_answer_t    expected_answers[$];
  bit               in_taken = 1'b0;
  bit               gaps_on = 1'b1;
  int unsigned      send_gap = 0;
  int unsigned      recv_gap = 0;
  int unsigned      fail_cnt = 0;
  int unsigned      sent_cnt = 0;
  int unsigned      result_cnt = 0;
  int unsigned      prime_cnt = 0;
  int unsigned      nofit_cnt = 0;

  next_prime_search_core u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  function automatic bit trial_prime(longint unsigned v);
    longint unsigned d;
    if (v < 2) return 1'b0;
    if (v < 4) return 1'b1;
    if (v[0] == 1'b0) return 1'b0;
    for (d = 3; d <= v / d; d += 2) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic prime_answer_t predict_prime_answer(logic [WIDTH-1:0] n);
    prime_answer_t   a;
    longint unsigned top;
    longint unsigned m;
    top = {WIDTH{1'b1}};
    m = n;
    a.number     = n;
    a.num_prime  = trial_prime(n);
    a.next_prime = '0;
    a.none_fits  = 1'b1;
    while (m < top) begin
      m++;
      if (trial_prime(m)) begin
        a.next_prime = m[WIDTH-1:0];
        a.none_fits  = 1'b0;
        break;
      end
    end
    return a;
  endfunction

  // accept/check at the rising edge
  always @(posedge clk) begin
    prime_answer_t exp_a;
    in_taken = 1'b0;
    if (rst_n) begin
      if (in_tvalid && in_tready) begin
        expected_answers.push_back(predict_prime_answer(in_tdata[WIDTH-1:0]));
        in_taken = 1'b1;
        sent_cnt++;
      end
      if (out_tvalid && out_tready) begin
        if (expected_answers.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, got %h", $time, out_tdata);
          fail_cnt++;
        end else begin
          exp_a = expected_answers.pop_front();
          result_cnt++;
          if (exp_a.num_prime) prime_cnt++;
          if (exp_a.none_fits) nofit_cnt++;
          if (out_tdata[0] !== exp_a.num_prime) begin
            $display("%0t: n=%0d prime flag expected %0d, got %0b", $time,
                     exp_a.number, exp_a.num_prime, out_tdata[0]);
            fail_cnt++;
          end
          if (out_tdata[WIDTH:1] !== exp_a.next_prime) begin
            $display("%0t: n=%0d next_prime expected %0d, got %0d", $time,
                     exp_a.number, exp_a.next_prime, out_tdata[WIDTH:1]);
            fail_cnt++;
          end
          if (out_tdata[WIDTH+1] !== exp_a.none_fits) begin
            $display("%0t: n=%0d no_prime_fits expected %0d, got %0b", $time,
                     exp_a.number, exp_a.none_fits, out_tdata[WIDTH+1]);
            fail_cnt++;
          end
        end
      end
    end
  end

  // input driver
  always @(negedge clk) begin
    logic                  v;
    logic [IN_TDATA_W-1:0] d;
    v = in_tvalid;
    d = in_tdata;
    if (rst_n) begin
      if (in_taken) v = 1'b0;
      if (!v) begin
        if (send_gap > 0) begin
          send_gap--;
        end else if (pending_numbers.size() > 0) begin
          d = '0;
          d[WIDTH-1:0] = pending_numbers.pop_front();
          v = 1'b1;
          if (gaps_on && $urandom_range(0, 3) == 0) send_gap = $urandom_range(1, 16);
        end
      end
    end
    in_tvalid <= v;
    in_tdata  <= d;
  end

  // result-side backpressure
  always @(negedge clk) begin
    logic r;
    r = 1'b1;
    if (recv_gap > 0) begin
      recv_gap--;
      r = 1'b0;
    end else if (gaps_on && $urandom_range(0, 7) == 0) begin
      recv_gap = $urandom_range(0, 15);
      r = 1'b0;
    end
    out_tready <= r;
  end

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("Timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
             expected_answers.size());
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [WIDTH-1:0] directed[$];
    logic [WIDTH-1:0] n;
    int unsigned      pick;
    // zero/one, tiny primes, squares of primes right above n, 16-bit edges,
    // top of range where nothing fits
    directed = '{32'd0, 32'd1, 32'd2, 32'd3, 32'd4, 32'd5, 32'd7, 32'd8, 32'd9,
                 32'd24, 32'd48, 32'd120, 32'd168, 32'd255, 32'd256, 32'd65521,
                 32'd65535, 32'h00FF_FFFF, 32'hFFFF_FFFC, 32'hFFFF_FFFD,
                 32'hFFFF_FFFE, 32'hFFFF_FFFF};
    repeat (2) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) pending_numbers.push_back(directed[i]);

    // drain completely before the random part
    while (pending_numbers.size() > 0 || in_tvalid || expected_answers.size() > 0)
      @(posedge clk);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      while (pending_numbers.size() >= 2) @(posedge clk);
      if (i == RANDOM_ITEMS - QUIET_TAIL) gaps_on = 1'b0;
      pick = $urandom_range(0, 99);
      if (pick < 5)       n = $urandom_range(0, 3);
      else if (pick < 80) n = $urandom_range(0, 4095);
      else if (pick < 95) n = $urandom_range(4096, 65535);
      else if (pick < 98) n = $urandom_range(65536, 1048575);
      else                n = {{(WIDTH-2){1'b1}}, $urandom_range(0, 1) ? 2'b11 : 2'b10};
      pending_numbers.push_back(n);
    end

    while (pending_numbers.size() > 0 || in_tvalid || expected_answers.size() > 0)
      @(posedge clk);
    repeat (2000) @(posedge clk);

    $display("Sent %0d numbers, checked %0d results: %0d prime inputs, %0d with no prime above",
             sent_cnt, result_cnt, prime_cnt, nofit_cnt);
    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

>>> next_prime_search_core.f
rtl/nps_pkg.sv
rtl/next_prime_search_core.sv
bench/next_prime_search_core_test.sv
